>>> rtl/rcmt_pkg.sv
// rcmt_pkg: shared types and codes of the repeat command match table
// holds the entry key layout and the command kind codes
// no dependencies
`timescale 1ns / 1ps

package rcmt_pkg;

  // command kinds on the input channel
  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_FIND   = 3'd1;
  localparam logic [2:0] KIND_DELETE = 3'd2;
  localparam logic [2:0] KIND_TICK   = 3'd3;
  localparam logic [2:0] KIND_STOP   = 3'd4;

  // address mode that compares only the short group address
  localparam logic [1:0] MODE_GROUP = 2'd1;

  localparam logic [31:0] TIMEOUT_RESET = 32'd30000;

  typedef struct packed {
    logic [15:0] cluster;
    logic [7:0]  src_ep;
    logic [7:0]  dst_ep;
    logic [1:0]  mode;
    logic [63:0] addr;
  } rcmt_key_t;

  typedef struct packed {
    rcmt_key_t  key;
    logic [7:0] cmd;
  } rcmt_entry_t;

endpackage

>>> rtl/rcmt_mem.sv
// rcmt_mem: entry storage, one write port and one registered read port
// holds key and command id of every table entry
// depends on rcmt_pkg
`timescale 1ns / 1ps

module rcmt_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  rcmt_pkg::rcmt_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output rcmt_pkg::rcmt_entry_t rd_data
);
  import rcmt_pkg::*;

  rcmt_entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/rcmt_match.sv
// rcmt_match: key compare of one stored entry against the query key
// group mode compares only the low 16 address bits
// depends on rcmt_pkg
`timescale 1ns / 1ps

module rcmt_match (
  input  logic               entry_ok,
  input  rcmt_pkg::rcmt_key_t stored,
  input  rcmt_pkg::rcmt_key_t query,
  output logic               match
);
  import rcmt_pkg::*;

  logic head_eq;
  logic addr_eq;

  // cluster, endpoints and mode must agree
  assign head_eq = (stored.cluster == query.cluster) && (stored.src_ep == query.src_ep) &&
                   (stored.dst_ep == query.dst_ep) && (stored.mode == query.mode);

  // address compare width depends on the stored mode
  assign addr_eq = (stored.mode == MODE_GROUP) ? (stored.addr[15:0] == query.addr[15:0])
                                               : (stored.addr == query.addr);

  assign match = entry_ok && head_eq && addr_eq;

endmodule

>>> rtl/repeat_command_match_table.sv
// channel   | signals                                   | transfer when
// ----------+-------------------------------------------+-------------------------
// command   | in_valid/in_ready, kind..command_id       | in_valid & in_ready
// result    | out_valid/out_ready, hit..add_count       | out_valid & out_ready
// config    | cfg_wr_en, cfg_wr_data (clear timeout)    | cfg_wr_en
//
// find and delete scan the entry memory one address per cycle, set by the single read
// port of the memory; find stops at its first hit. add walks the valid bits one per
// cycle; tick, stop and other kinds go from idle straight to the result state.
// one command at a time; in_ready is high only between commands, and a finished
// result waits in the output register while the next command is taken.
// rst is synchronous; it clears valid bits, count, timeout and handshake state.
`timescale 1ns / 1ps

module repeat_command_match_table #(
  parameter int ENTRIES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [15:0] cluster_id,
  input  logic [7:0]  source_endpoint,
  input  logic [7:0]  dest_endpoint,
  input  logic [1:0]  address_mode,
  input  logic [63:0] dest_address,
  input  logic [7:0]  command_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [5:0]  entry_index,
  output logic [7:0]  stored_command_id,
  output logic        add_ok,
  output logic        timeout_fired,
  output logic [7:0]  add_count
);
  import rcmt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_ADD, ST_SCAN, ST_FIN} state_t;

  state_t             state;
  logic [ENTRIES-1:0] entry_valid;
  logic [31:0]        clear_timeout_ticks;
  logic [31:0]        ticks_left;
  logic               timeout_active;
  logic [7:0]         adds;
  logic [7:0]         adds_next;

  // latched command
  logic [2:0]  q_kind;
  rcmt_key_t   q_key;
  logic [7:0]  q_cmd;

  // scan pointers
  logic [IDX_W-1:0] rd_idx;
  logic             issue_done;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_vld;

  // pending result
  logic             res_hit;
  logic [IDX_W-1:0] res_idx;
  logic [7:0]       res_cmd;
  logic             res_add_ok;
  logic             res_fired;

  // memory ports
  logic        rd_en;
  logic        wr_en;
  rcmt_entry_t wr_data;
  rcmt_entry_t rd_data;
  logic        match;
  rcmt_key_t   in_key;

  assign in_key = '{cluster: cluster_id, src_ep: source_endpoint, dst_ep: dest_endpoint,
                    mode: address_mode, addr: dest_address};

  assign in_ready  = (state == ST_IDLE);
  assign rd_en     = (state == ST_SCAN) && !issue_done;
  assign wr_en     = (state == ST_ADD) && !entry_valid[rd_idx];
  assign wr_data   = '{key: q_key, cmd: q_cmd};
  assign adds_next = adds + 8'd1;

  rcmt_mem #(
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rd_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  rcmt_match u_match (
    .entry_ok (entry_valid[cmp_idx]),
    .stored   (rd_data.key),
    .query    (q_key),
    .match    (match)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      clear_timeout_ticks <= cfg_wr_data;
    end
  end

  // latched command, taken on input transfer
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_kind <= kind;
      q_key  <= in_key;
      q_cmd  <= command_id;
    end
  end

  // sequencer, table state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      entry_valid    <= '0;
      adds           <= '0;
      timeout_active <= 1'b0;
      ticks_left     <= '0;
      rd_idx         <= '0;
      issue_done     <= 1'b0;
      cmp_idx        <= '0;
      cmp_vld        <= 1'b0;
      out_valid      <= 1'b0;
      res_hit        <= 1'b0;
      res_idx        <= '0;
      res_cmd        <= '0;
      res_add_ok     <= 1'b0;
      res_fired      <= 1'b0;
    end else begin
      // compare stage follows the read issued last cycle
      cmp_vld <= rd_en;
      cmp_idx <= rd_idx;

      // output register drains unless a new result is loaded
      if (out_valid && out_ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            res_hit    <= 1'b0;
            res_idx    <= '0;
            res_cmd    <= '0;
            res_add_ok <= 1'b0;
            res_fired  <= 1'b0;
            rd_idx     <= '0;
            issue_done <= 1'b0;
            unique case (kind)
              KIND_ADD: begin
                state <= ST_ADD;
              end
              KIND_FIND, KIND_DELETE: begin
                state <= ST_SCAN;
              end
              KIND_TICK: begin
                if (timeout_active) begin
                  if (ticks_left <= 32'd1) begin
                    ticks_left     <= '0;
                    timeout_active <= 1'b0;
                    adds           <= '0;
                    entry_valid    <= '0;
                    res_fired      <= 1'b1;
                  end else begin
                    ticks_left <= ticks_left - 32'd1;
                  end
                end
                state <= ST_FIN;
              end
              KIND_STOP: begin
                adds           <= '0;
                timeout_active <= 1'b0;
                ticks_left     <= '0;
                state          <= ST_FIN;
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end

        // walk valid bits for the lowest free entry; memory write happens here
        ST_ADD: begin
          if (!entry_valid[rd_idx]) begin
            entry_valid[rd_idx] <= 1'b1;
            adds                <= adds_next;
            if (adds_next == 8'd1) begin
              timeout_active <= 1'b1;
              ticks_left     <= clear_timeout_ticks;
            end
            res_add_ok <= 1'b1;
            res_idx    <= rd_idx;
            state      <= ST_FIN;
          end else if (rd_idx == LAST_IDX) begin
            state <= ST_FIN;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end

        // pipelined read and compare over all entries; find stops at its first hit
        ST_SCAN: begin
          if (rd_en) begin
            if (rd_idx == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              rd_idx <= rd_idx + 1'b1;
            end
          end
          if (cmp_vld) begin
            if (q_kind == KIND_FIND) begin
              if (match) begin
                res_hit <= 1'b1;
                res_idx <= cmp_idx;
                res_cmd <= rd_data.cmd;
                state   <= ST_FIN;
              end else if (cmp_idx == LAST_IDX) begin
                state <= ST_FIN;
              end
            end else begin
              if (match) begin
                entry_valid[cmp_idx] <= 1'b0;
              end
              if (cmp_idx == LAST_IDX) begin
                state <= ST_FIN;
              end
            end
          end
        end

        // hand the result to the output register once it is free
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid         <= 1'b1;
            hit               <= res_hit;
            entry_index       <= 6'(res_idx);
            stored_command_id <= res_cmd;
            add_ok            <= res_add_ok;
            timeout_fired     <= res_fired;
            add_count         <= adds;
            state             <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/rcmt_checker.sv
// rcmt_props: port level checks of the repeat command match table
// bound to the top level; sees only its ports
// depends on repeat_command_match_table
`timescale 1ns / 1ps

module rcmt_props (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [5:0]  entry_index,
  input logic [7:0]  stored_command_id,
  input logic        add_ok,
  input logic        timeout_fired,
  input logic [7:0]  add_count
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(entry_index) &&
      $stable(stored_command_id) && $stable(add_ok) && $stable(timeout_fired) &&
      $stable(add_count))
    else $error("result changed while stalled");

  // one command at a time: busy right after an input transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a command is in progress");

  // no result reports more than one of a find hit, an add and a timeout expiry
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && add_ok) && !(hit && timeout_fired) && !(add_ok && timeout_fired))
    else $error("result reports more than one kind");

  // expiry clears the add count
  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && timeout_fired |-> add_count == 8'd0)
    else $error("timeout fired with nonzero add count");

  // an index or command id is reported only for a hit or a filled entry
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit && !add_ok |-> entry_index == 6'd0 && stored_command_id == 8'd0)
    else $error("index or command id without hit or add");

endmodule

bind repeat_command_match_table rcmt_props u_rcmt_props (.*);
